@@ hw/rtl/shq_pkg.sv @@
// Shared types, constants and helpers for the sensor health qualifier.
// No dependencies; every other file in this block uses it by scoped names.
package shq_pkg;

    localparam int SAMPLE_W = 10;
    localparam int COUNT_W  = 8;
    localparam int CHANNEL_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int HEALTH_W   = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_TOLERANCE = 2'd3;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] VALID_LOW_RST      = 10'd10;
    localparam logic [SAMPLE_W-1:0] VALID_HIGH_RST     = 10'd1013;
    localparam logic [COUNT_W-1:0]  REPEAT_LIMIT_RST   = 8'd10;
    localparam logic [SAMPLE_W-1:0] SAME_TOLERANCE_RST = 10'd2;

    typedef enum logic [HEALTH_W-1:0] {
        HEALTH_OK           = 2'd0,
        HEALTH_DISCONNECTED = 2'd1,
        HEALTH_STUCK        = 2'd2
    } health_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] valid_low;
        logic [SAMPLE_W-1:0] valid_high;
        logic [COUNT_W-1:0]  repeat_limit;
        logic [SAMPLE_W-1:0] same_tolerance;
    } cfg_t;

    // One channel's tracking state, as stored in one memory word
    typedef struct packed {
        logic [SAMPLE_W-1:0] held_ref;
        logic [COUNT_W-1:0]  repeat_cnt;
        logic [COUNT_W-1:0]  fault_run;
        logic [SAMPLE_W-1:0] last_good;
    } entry_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ hw/rtl/shq_sample_if.sv @@
// Sample channel: valid/ready stream carrying a channel tag and an ADC reading.
// Depends on shq_pkg for the channel and sample widths.
interface shq_sample_if;
    logic                          valid;
    logic                          ready;
    logic [shq_pkg::CHANNEL_W-1:0] channel;
    logic [shq_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

@@ hw/rtl/shq_result_if.sv @@
// Result channel: valid/ready stream carrying one health verdict per sample.
// Depends on shq_pkg for field widths.
interface shq_result_if;
    logic                         valid;
    logic                         ready;
    logic [shq_pkg::HEALTH_W-1:0] health;
    logic [shq_pkg::COUNT_W-1:0]  error_run;
    logic [shq_pkg::SAMPLE_W-1:0] good_value;
    logic                         fault_seen;

    modport source (output valid, output health, output error_run,
                    output good_value, output fault_seen, input ready);
    modport sink   (input valid, input health, input error_run,
                    input good_value, input fault_seen, output ready);
endinterface

@@ hw/rtl/shq_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on shq_pkg for index and data widths.
interface shq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [shq_pkg::CFG_IDX_W-1:0]  index;
    logic [shq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/shq_cfg_regs.sv @@
// Configuration register bank of the sensor health qualifier.
// Depends on shq_pkg for register indexes, reset values and cfg_t.
module shq_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [shq_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [shq_pkg::CFG_DATA_W-1:0] wr_data,
    output shq_pkg::cfg_t                  cfg
);

    shq_pkg::cfg_t cfg_reg;
    shq_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                shq_pkg::CFG_VALID_LOW:
                    cfg_next.valid_low = wr_data[shq_pkg::SAMPLE_W-1:0];
                shq_pkg::CFG_VALID_HIGH:
                    cfg_next.valid_high = wr_data[shq_pkg::SAMPLE_W-1:0];
                shq_pkg::CFG_REPEAT_LIMIT:
                    cfg_next.repeat_limit = wr_data[shq_pkg::COUNT_W-1:0];
                shq_pkg::CFG_SAME_TOLERANCE:
                    cfg_next.same_tolerance = wr_data[shq_pkg::SAMPLE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_low      <= shq_pkg::VALID_LOW_RST;
            cfg_reg.valid_high     <= shq_pkg::VALID_HIGH_RST;
            cfg_reg.repeat_limit   <= shq_pkg::REPEAT_LIMIT_RST;
            cfg_reg.same_tolerance <= shq_pkg::SAME_TOLERANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/shq_state_mem.sv @@
// Per-channel state memory: one write port, one registered read port,
// valid bits so never-written entries read as zero. Depends on shq_pkg.
module shq_state_mem #(
    parameter int CHANNELS = 3,
    parameter int ADDR_W   = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output shq_pkg::entry_t     rd_entry,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  shq_pkg::entry_t     wr_entry
);

    shq_pkg::entry_t       mem [CHANNELS];
    shq_pkg::entry_t       rd_data_reg;
    logic                  rd_hit_reg;
    logic [CHANNELS-1:0]   valid_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written entries and whether the last read hit one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

@@ hw/rtl/shq_update.sv @@
// Classification and state update for one sample against its channel entry.
// Purely combinational; depends on shq_pkg for cfg_t, entry_t and health_t.
module shq_update (
    input  shq_pkg::cfg_t                 cfg,
    input  logic [shq_pkg::SAMPLE_W-1:0]  sample,
    input  shq_pkg::entry_t               cur,
    output shq_pkg::entry_t               nxt,
    output shq_pkg::health_t              health,
    output logic                          fault
);

    logic                          in_window;
    logic [shq_pkg::SAMPLE_W-1:0]  diff;
    logic [shq_pkg::COUNT_W-1:0]   cnt_inc;
    logic                          stuck;

    assign in_window = (sample >= cfg.valid_low) && (sample <= cfg.valid_high);
    assign diff      = (sample >= cur.held_ref) ? sample - cur.held_ref
                                                : cur.held_ref - sample;
    assign cnt_inc   = shq_pkg::sat_inc(cur.repeat_cnt);

    // Stuck tracking, skipped for out-of-window samples
    always_comb
    begin
        nxt   = cur;
        stuck = 1'b0;
        if (in_window)
        begin
            if (diff <= cfg.same_tolerance)
            begin
                nxt.repeat_cnt = cnt_inc;
                stuck          = (cnt_inc >= cfg.repeat_limit);
            end
            else
            begin
                nxt.held_ref   = sample;
                nxt.repeat_cnt = shq_pkg::COUNT_W'(1);
            end
        end

        fault = !in_window || stuck;
        if (!in_window)
        begin
            health = shq_pkg::HEALTH_DISCONNECTED;
        end
        else if (stuck)
        begin
            health = shq_pkg::HEALTH_STUCK;
        end
        else
        begin
            health = shq_pkg::HEALTH_OK;
        end

        // Fault run and last good value
        if (fault)
        begin
            nxt.fault_run = shq_pkg::sat_inc(cur.fault_run);
        end
        else
        begin
            nxt.fault_run = '0;
            nxt.last_good = sample;
        end
    end

endmodule

@@ hw/rtl/sensor_health_qualifier.sv @@
// Sensor health qualifier top level: accept stage, state memory, update and
// result register. Depends on shq_pkg, the three shq_*_if interfaces,
// shq_cfg_regs, shq_state_mem and shq_update.
//
//   Channel   Role    Payload
//   samples   sink    channel, sample
//   results   source  health, error_run, good_value, fault_seen
//   cfg       sink    index, data (register write, always ready)
//
// Throughput is one sample per cycle while results are being taken. A sample
// is registered in the update stage, and its result then goes into the output
// register. The memory read is issued on the sample transfer and the update
// writes back as its result enters the output register; a same-channel sample
// right behind it takes the freshly written entry from a forwarding register.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// A result not taken holds in the output register; the update stage behind
// it holds too, and samples stall only when both are full.
module sensor_health_qualifier #(
    parameter int CHANNELS = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    shq_sample_if.sink    samples,
    shq_result_if.source  results,
    shq_cfg_if.sink       cfg
);

    localparam int CH_W = shq_pkg::CHANNEL_W;

    shq_pkg::cfg_t     cfg_q;
    shq_pkg::entry_t   rd_entry;
    shq_pkg::entry_t   cur_entry;
    shq_pkg::entry_t   nxt_entry;
    shq_pkg::health_t  upd_health;
    logic              upd_fault;

    logic              accept;
    logic              advance;
    logic              commit;
    logic              in_range;
    logic              sticky_next;

    logic              s1_valid_reg;
    logic              s1_in_range_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic [shq_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic              fwd_reg;
    shq_pkg::entry_t   fwd_entry_reg;
    logic              sticky_reg;

    logic              out_valid_reg;
    shq_pkg::health_t  out_health_reg;
    logic [shq_pkg::COUNT_W-1:0]  out_run_reg;
    logic [shq_pkg::SAMPLE_W-1:0] out_good_reg;
    logic              out_seen_reg;

    // Configuration registers
    assign cfg.ready = 1'b1;

    shq_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // Handshake and pipeline control
    assign advance       = !out_valid_reg || results.ready;
    assign commit        = s1_valid_reg && advance;
    assign samples.ready = !s1_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;
    assign in_range      = (int'(samples.channel) < CHANNELS);

    shq_state_mem #(
        .CHANNELS (CHANNELS),
        .ADDR_W   (CH_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept && in_range),
        .rd_addr  (samples.channel),
        .rd_entry (rd_entry),
        .wr_en    (commit && s1_in_range_reg),
        .wr_addr  (s1_ch_reg),
        .wr_entry (nxt_entry)
    );

    // Take the forwarded entry when the previous sample wrote this channel
    assign cur_entry = fwd_reg ? fwd_entry_reg : rd_entry;

    shq_update u_upd (
        .cfg    (cfg_q),
        .sample (s1_sample_reg),
        .cur    (cur_entry),
        .nxt    (nxt_entry),
        .health (upd_health),
        .fault  (upd_fault)
    );

    assign sticky_next = sticky_reg || (s1_in_range_reg && upd_fault);

    // Update stage control and sticky flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= commit && s1_in_range_reg
                                && (samples.channel == s1_ch_reg);
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                sticky_reg    <= sticky_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Update stage payload and forwarding data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg       <= samples.channel;
            s1_sample_reg   <= samples.sample;
            s1_in_range_reg <= in_range;
            fwd_entry_reg   <= nxt_entry;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_health_reg <= s1_in_range_reg ? upd_health : shq_pkg::HEALTH_OK;
            out_run_reg    <= s1_in_range_reg ? nxt_entry.fault_run : '0;
            out_good_reg   <= s1_in_range_reg ? nxt_entry.last_good : '0;
            out_seen_reg   <= sticky_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.health     = out_health_reg;
    assign results.error_run  = out_run_reg;
    assign results.good_value = out_good_reg;
    assign results.fault_seen = out_seen_reg;

endmodule

@@ hw/rtl/shq_checker.sv @@
// Port-level checks for the sensor health qualifier, bound to the top level.
// Depends on shq_pkg for field widths and health codes.
module shq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [shq_pkg::HEALTH_W-1:0] health,
    input logic [shq_pkg::COUNT_W-1:0]  error_run,
    input logic                         fault_seen
);

    logic [2:0] pending_reg;
    logic       seen_reg;

    // Count samples in flight and remember a reported fault
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_valid && in_ready)
                                       - 3'(out_valid && out_ready);
            if (out_valid && out_ready && fault_seen)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    // A result needs a sample behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 3'd0))
        else $error("result shown with no sample in flight");

    // Sticky flag never drops once reported
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_reg) |-> fault_seen)
        else $error("fault_seen dropped after being reported");

    // A fault verdict carries a nonzero run and the sticky flag
    a_fault_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && health != shq_pkg::HEALTH_OK) |-> (error_run != '0 && fault_seen))
        else $error("fault reported without run count or sticky flag");

    // A held result stays valid until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before transfer");

endmodule

bind sensor_health_qualifier shq_checker u_shq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .health     (results.health),
    .error_run  (results.error_run),
    .fault_seen (results.fault_seen)
);

@@ bench/shq_checker.sv @@
// Checker for the sensor health qualifier: watches the sample, result and
// register channels, predicts each verdict and compares it with the output.
// Depends on shq_pkg and the shq_sample_if, shq_result_if, shq_cfg_if interfaces.
module shq_bench_checker #(
    parameter int CHANNELS = 3
) (
    input  logic  clk,
    input  logic  rst_n,
    shq_sample_if samples,
    shq_result_if results,
    shq_cfg_if    cfg,
    output int    mismatches,
    output int    verdicts_outstanding,
    output int    ok_seen,
    output int    disc_seen,
    output int    stuck_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        shq_pkg::health_t             health;
        logic [shq_pkg::COUNT_W-1:0]  error_run;
        logic [shq_pkg::SAMPLE_W-1:0] good_value;
        logic                         fault_seen;
    } verdict_t;

    // Local copy of the register file and per-channel tracking state
    shq_pkg::cfg_t                settings;
    logic [shq_pkg::SAMPLE_W-1:0] ref_value   [CHANNELS];
    logic [shq_pkg::COUNT_W-1:0]  repeat_run  [CHANNELS];
    logic [shq_pkg::COUNT_W-1:0]  fault_count [CHANNELS];
    logic [shq_pkg::SAMPLE_W-1:0] good_sample [CHANNELS];
    logic                         any_fault;

    verdict_t verdicts_due [$];

    // Classify one sample and advance the channel's tracking state
    function automatic verdict_t grade_sample(input logic [shq_pkg::CHANNEL_W-1:0] ch,
                                              input logic [shq_pkg::SAMPLE_W-1:0] s);
        verdict_t                     v;
        int                           idx;
        logic [shq_pkg::SAMPLE_W-1:0] spread;
        v.health     = shq_pkg::HEALTH_OK;
        v.error_run  = '0;
        v.good_value = '0;
        v.fault_seen = any_fault;
        // Unknown channel: report only the sticky flag, touch nothing
        if (int'(ch) >= CHANNELS)
            return v;
        idx = int'(ch);
        if (s < settings.valid_low || s > settings.valid_high)
        begin
            v.health = shq_pkg::HEALTH_DISCONNECTED;
        end
        else
        begin
            spread = (s >= ref_value[idx]) ? s - ref_value[idx] : ref_value[idx] - s;
            if (spread <= settings.same_tolerance)
            begin
                if (repeat_run[idx] != '1)
                    repeat_run[idx] = repeat_run[idx] + 1'b1;
                if (repeat_run[idx] >= settings.repeat_limit)
                    v.health = shq_pkg::HEALTH_STUCK;
            end
            else
            begin
                ref_value[idx]  = s;
                repeat_run[idx] = shq_pkg::COUNT_W'(1);
            end
        end
        if (v.health != shq_pkg::HEALTH_OK)
        begin
            if (fault_count[idx] != '1)
                fault_count[idx] = fault_count[idx] + 1'b1;
            any_fault = 1'b1;
        end
        else
        begin
            fault_count[idx] = '0;
            good_sample[idx] = s;
        end
        v.error_run  = fault_count[idx];
        v.good_value = good_sample[idx];
        v.fault_seen = any_fault;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            settings.valid_low      = shq_pkg::VALID_LOW_RST;
            settings.valid_high     = shq_pkg::VALID_HIGH_RST;
            settings.repeat_limit   = shq_pkg::REPEAT_LIMIT_RST;
            settings.same_tolerance = shq_pkg::SAME_TOLERANCE_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ref_value[i]   = '0;
                repeat_run[i]  = '0;
                fault_count[i] = '0;
                good_sample[i] = '0;
            end
            any_fault = 1'b0;
            verdicts_due.delete();
            mismatches = 0;
            ok_seen    = 0;
            disc_seen  = 0;
            stuck_seen = 0;
        end
        else
        begin
            // Register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    shq_pkg::CFG_VALID_LOW:
                        settings.valid_low = cfg.data;
                    shq_pkg::CFG_VALID_HIGH:
                        settings.valid_high = cfg.data;
                    shq_pkg::CFG_REPEAT_LIMIT:
                        settings.repeat_limit = cfg.data[shq_pkg::COUNT_W-1:0];
                    shq_pkg::CFG_SAME_TOLERANCE:
                        settings.same_tolerance = cfg.data;
                    default: ;
                endcase
            end
            // Compare a result transfer against the oldest expectation
            if (results.valid && results.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result transfer with no sample waiting: health %0d",
                           results.health);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    case (want.health)
                        shq_pkg::HEALTH_OK:           ok_seen++;
                        shq_pkg::HEALTH_DISCONNECTED: disc_seen++;
                        default:                      stuck_seen++;
                    endcase
                    if (results.health !== want.health)
                    begin
                        $error("health: expected %0d, got %0d", want.health, results.health);
                        mismatches++;
                    end
                    if (results.error_run !== want.error_run)
                    begin
                        $error("error_run: expected %0d, got %0d",
                               want.error_run, results.error_run);
                        mismatches++;
                    end
                    if (results.good_value !== want.good_value)
                    begin
                        $error("good_value: expected %0d, got %0d",
                               want.good_value, results.good_value);
                        mismatches++;
                    end
                    if (results.fault_seen !== want.fault_seen)
                    begin
                        $error("fault_seen: expected %0d, got %0d",
                               want.fault_seen, results.fault_seen);
                        mismatches++;
                    end
                end
            end
            // Predict the verdict of an accepted sample
            if (samples.valid && samples.ready)
                verdicts_due.push_back(grade_sample(samples.channel, samples.sample));
        end
        verdicts_outstanding = verdicts_due.size();
    end

endmodule

@@ bench/sensor_health_qualifier_test.sv @@
// Top-level bench for sensor_health_qualifier: clock, reset, register setup,
// sample stimulus, result back-pressure, watchdog and final verdict.
// Depends on shq_pkg, the shq_*_if interfaces, the block and shq_bench_checker.
module sensor_health_qualifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS     = 3;
    localparam int CH_W         = shq_pkg::CHANNEL_W;
    localparam int SMP_W        = shq_pkg::SAMPLE_W;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SAMPLE_MAX   = (1 << shq_pkg::SAMPLE_W) - 1;
    localparam int COUNT_MAX    = (1 << shq_pkg::COUNT_W) - 1;
    localparam int LOW_RST      = int'(shq_pkg::VALID_LOW_RST);
    localparam int HIGH_RST     = int'(shq_pkg::VALID_HIGH_RST);
    localparam int LIMIT_RST    = int'(shq_pkg::REPEAT_LIMIT_RST);
    localparam int TOL_RST      = int'(shq_pkg::SAME_TOLERANCE_RST);
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 71;
    localparam int HOLD_PHASE   = 3;
    localparam int SAT_RUN      = 270;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 6;
    localparam int STALL_LIMIT  = 2000;

    typedef enum int {
        DRAIN_FULL,
        DRAIN_HALF,
        DRAIN_SPARSE,
        DRAIN_MOSTLY
    } drain_style_t;

    logic clk = 1'b0;
    logic rst_n;

    shq_sample_if sample_bus ();
    shq_result_if result_bus ();
    shq_cfg_if    cfg_bus ();

    int mismatches;
    int verdicts_outstanding;
    int ok_seen;
    int disc_seen;
    int stuck_seen;
    int items_sent   = 0;
    int reg_writes   = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    bit steady_feed  = 1'b0;
    bit hold_req     = 1'b0;
    int cur_low;
    int cur_high;
    int cur_limit;
    int cur_tol;

    sensor_health_qualifier #(.CHANNELS(CHANNELS)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (result_bus),
        .cfg     (cfg_bus)
    );

    shq_bench_checker #(.CHANNELS(CHANNELS)) health_check (
        .clk                  (clk),
        .rst_n                (rst_n),
        .samples              (sample_bus),
        .results              (result_bus),
        .cfg                  (cfg_bus),
        .mismatches           (mismatches),
        .verdicts_outstanding (verdicts_outstanding),
        .ok_seen              (ok_seen),
        .disc_seen            (disc_seen),
        .stuck_seen           (stuck_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: end the run after a long stretch with no transfer anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
                   || (result_bus.valid && result_bus.ready)
                   || (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result back-pressure: random stall styles, plus one long hold on request
    initial
    begin
        drain_style_t style;
        int           span;
        style = DRAIN_FULL;
        span  = 0;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                style = drain_style_t'($urandom_range(0, 3));
                span  = $urandom_range(10, 80);
            end
            span--;
            case (style)
                DRAIN_FULL:   result_bus.ready <= 1'b1;
                DRAIN_HALF:   result_bus.ready <= ($urandom_range(0, 1) == 1);
                DRAIN_SPARSE: result_bus.ready <= ($urandom_range(0, 3) == 0);
                default:      result_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic [SMP_W-1:0] clip_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return SMP_W'(SAMPLE_MAX);
        return SMP_W'(v);
    endfunction

    // Offer one sample and hold it until it transfers; insert burst gaps
    task automatic drive_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s);
        int pause;
        if (burst_left == 0 && !steady_feed)
        begin
            pause = $urandom_range(0, 6);
            if (pause > 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        sample_bus.valid   <= 1'b1;
        sample_bus.channel <= ch;
        sample_bus.sample  <= s;
        do @(posedge clk); while (!sample_bus.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Write one register; valid stays up for the caller to lower
    task automatic write_reg(input logic [shq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [shq_pkg::CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic write_settings(input int lo, input int hi, input int lim, input int tol);
        cur_low   = lo;
        cur_high  = hi;
        cur_limit = lim;
        cur_tol   = tol;
        write_reg(shq_pkg::CFG_VALID_LOW, shq_pkg::CFG_DATA_W'(lo));
        write_reg(shq_pkg::CFG_VALID_HIGH, shq_pkg::CFG_DATA_W'(hi));
        // upper data bits are don't-care for the 8-bit limit: randomize them
        write_reg(shq_pkg::CFG_REPEAT_LIMIT,
                  {2'($urandom_range(0, 3)), shq_pkg::COUNT_W'(lim)});
        write_reg(shq_pkg::CFG_SAME_TOLERANCE, shq_pkg::CFG_DATA_W'(tol));
        cfg_bus.valid <= 1'b0;
    endtask

    // Stop feeding and wait until every verdict has come back
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (verdicts_outstanding != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // One random sequence: a near-repeat run, a disconnected run, or noise
    task automatic emit_sequence();
        int kind;
        int len;
        int ch;
        int base;
        int reach;
        int val;
        kind  = $urandom_range(0, 9);
        ch    = $urandom_range(0, CHANNELS - 1);
        reach = (cur_tol >= SAMPLE_MAX) ? SAMPLE_MAX : cur_tol;
        if (kind <= 5)
        begin
            len  = $urandom_range(1, (cur_limit + 3 > 40) ? 40 : cur_limit + 3);
            base = (cur_low <= cur_high) ? int'($urandom_range(cur_low, cur_high))
                                         : int'($urandom_range(0, SAMPLE_MAX));
            repeat (len)
            begin
                if ($urandom_range(0, 7) == 0)
                    val = base + (($urandom_range(0, 1) == 1) ? reach + 1 : -(reach + 1));
                else
                    val = base + int'($urandom_range(0, 2 * reach)) - reach;
                drive_sample(CH_W'(ch), clip_sample(val));
                // interleave other traffic between same-channel samples
                if ($urandom_range(0, 5) == 0)
                    drive_sample(CH_W'($urandom_range(0, 3)),
                                 SMP_W'($urandom_range(0, SAMPLE_MAX)));
            end
        end
        else if (kind <= 7)
        begin
            len = $urandom_range(1, 6);
            repeat (len)
            begin
                if (cur_low > 0 && (cur_high >= SAMPLE_MAX || $urandom_range(0, 1) == 1))
                    val = int'($urandom_range(0, cur_low - 1));
                else if (cur_high < SAMPLE_MAX)
                    val = int'($urandom_range(cur_high + 1, SAMPLE_MAX));
                else
                    val = int'($urandom_range(0, SAMPLE_MAX));
                drive_sample(CH_W'(ch), clip_sample(val));
            end
        end
        else
        begin
            len = $urandom_range(1, 4);
            repeat (len)
                drive_sample(CH_W'($urandom_range(0, 3)),
                             SMP_W'($urandom_range(0, SAMPLE_MAX)));
        end
    endtask

    initial
    begin
        int phase;
        int target;
        sample_bus.valid   = 1'b0;
        sample_bus.channel = '0;
        sample_bus.sample  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = shq_pkg::CFG_VALID_LOW;
        cfg_bus.data       = '0;
        rst_n              = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset window, boundaries, unknown channel, stuck detection
        write_settings(LOW_RST, HIGH_RST, LIMIT_RST, TOL_RST);
        drive_sample(CH_W'(3), SMP_W'(SAMPLE_MAX));
        drive_sample(CH_W'(0), SMP_W'(12));
        drive_sample(CH_W'(0), '0);
        drive_sample(CH_W'(0), SMP_W'(SAMPLE_MAX));
        drive_sample(CH_W'(0), SMP_W'(LOW_RST - 1));
        drive_sample(CH_W'(0), SMP_W'(HIGH_RST + 1));
        drive_sample(CH_W'(0), SMP_W'(LOW_RST));
        drive_sample(CH_W'(0), SMP_W'(HIGH_RST));
        drive_sample(CH_W'(0), SMP_W'(682));
        drive_sample(CH_W'(0), SMP_W'(341));
        repeat (11) drive_sample(CH_W'(1), SMP_W'(500));
        drive_sample(CH_W'(1), SMP_W'(503));
        drive_sample(CH_W'(3), '0);
        settle();

        // Directed: zero repeat limit with the initial zero reference
        write_settings(0, SAMPLE_MAX, 0, 2);
        drive_sample(CH_W'(2), SMP_W'(1));
        drive_sample(CH_W'(2), '0);
        drive_sample(CH_W'(2), SMP_W'(600));
        settle();

        // Directed: empty window flags everything as disconnected
        write_settings(600, 400, LIMIT_RST, 2);
        drive_sample(CH_W'(0), SMP_W'(500));
        drive_sample(CH_W'(1), SMP_W'(600));
        drive_sample(CH_W'(2), SMP_W'(400));
        settle();

        // Random phases under changing register settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_settings(0, SAMPLE_MAX, 1, 0);
                1: write_settings(SAMPLE_MAX, 0, 0, SAMPLE_MAX);
                2: write_settings(0, SAMPLE_MAX, COUNT_MAX, SAMPLE_MAX);
                PHASES - 1: write_settings(int'($urandom_range(0, SAMPLE_MAX)),
                                           int'($urandom_range(0, SAMPLE_MAX)),
                                           int'($urandom_range(0, COUNT_MAX)),
                                           int'($urandom_range(0, SAMPLE_MAX)));
                default: write_settings(int'($urandom_range(0, 300)),
                                        int'($urandom_range(700, SAMPLE_MAX)),
                                        int'($urandom_range(0, 24)),
                                        int'($urandom_range(0, 12)));
            endcase
            steady_feed = (phase % 4 == 1) || (phase == HOLD_PHASE);
            // long receiver hold while samples keep coming: fills the pipeline
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                emit_sequence();
            steady_feed = 1'b0;
            settle();
        end

        // Saturate the repeat counter, then the fault run
        write_settings(LOW_RST, HIGH_RST, COUNT_MAX, 2);
        repeat (SAT_RUN) drive_sample(CH_W'(2), SMP_W'(700 + $urandom_range(0, 2)));
        repeat (SAT_RUN) drive_sample(CH_W'(0), SMP_W'($urandom_range(0, LOW_RST - 1)));
        settle();

        $display("Covered %0d samples and %0d register writes over %0d random phases",
                 items_sent, reg_writes, PHASES);
        $display("Verdicts checked: %0d ok, %0d disconnected, %0d stuck",
                 ok_seen, disc_seen, stuck_seen);
        if (mismatches == 0 && verdicts_outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/shq_pkg.sv
hw/rtl/shq_sample_if.sv
hw/rtl/shq_result_if.sv
hw/rtl/shq_cfg_if.sv
hw/rtl/shq_cfg_regs.sv
hw/rtl/shq_state_mem.sv
hw/rtl/shq_update.sv
hw/rtl/sensor_health_qualifier.sv
hw/rtl/shq_checker.sv
bench/shq_checker.sv
bench/sensor_health_qualifier_test.sv
